### hdl/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  localparam logic [1:0] CFG_HIGH_WAIT = 2'd0;
  localparam logic [1:0] CFG_LOW_WAIT  = 2'd1;

  localparam logic [15:0] HIGH_WAIT_RST = 16'd47;
  localparam logic [15:0] LOW_WAIT_RST  = 16'd40;

  localparam logic [3:0] LAST_BIT = 4'd9;

  typedef struct packed {
    logic       is_cmd;
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       scl_level;
    logic       sda_level;
  } item_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       rejected;
  } res_t;

endpackage
`default_nettype wire

### hdl/i2cm_front.sv
`default_nettype none
module i2cm_front
  import i2cm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_kind,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_tx_byte,
  input  wire logic       in_ack_to_send,
  input  wire logic       in_scl_level,
  input  wire logic       in_sda_level,
  output logic            q_valid,
  input  wire logic       q_ready,
  output item_t           q_item
);

  item_t       mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push, pop;
  item_t       item_in;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    item_in.is_cmd      = in_kind;
    item_in.cmd         = cmd_t'(in_command);
    item_in.tx_byte     = in_tx_byte;
    item_in.ack_to_send = in_ack_to_send;
    item_in.scl_level   = in_scl_level;
    item_in.sda_level   = in_sda_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule
`default_nettype wire

### hdl/i2cm_back.sv
`default_nettype none
module i2cm_back
  import i2cm_pkg::*;
#(
  parameter int WAIT_COUNTER_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire item_t       q_item,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output res_t             out_res
);

  localparam int WW = WAIT_COUNTER_WIDTH;
  localparam logic [32:0] WAIT_TOP = (33'd1 << WW) - 33'd1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_RISE, PH_ST_SETUP, PH_ST_HOLD, PH_ST_FALL,
    PH_BIT_LOW, PH_BIT_RISE, PH_BIT_HIGH, PH_BIT_FALL,
    PH_SP_FALL, PH_SP_LOW, PH_SP_RISE, PH_SP_SETUP, PH_SP_HOLD,
    PH_BYTE_PREP
  } phase_t;

  function automatic logic [WW-1:0] wait_load(input logic [15:0] ticks);
    logic [32:0] n;
    n = {17'd0, (ticks == 16'd0) ? 16'd1 : ticks};
    return (n > WAIT_TOP) ? WAIT_TOP[WW-1:0] : n[WW-1:0];
  endfunction

  function automatic logic bit_pull(input logic [3:0] idx, input logic [7:0] sw,
                                    input logic ack);
    logic v;
    v = (idx < 4'd8) ? sw[3'(3'd7 - idx[2:0])] : ack;
    return ~v;
  endfunction

  logic [15:0]   high_wait_r, low_wait_r;
  phase_t        phase_r, phase_nxt;
  logic [3:0]    bit_idx_r, bit_idx_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [WW-1:0] wait_r, wait_nxt;
  logic          scl_r, scl_nxt;
  logic          sda_r, sda_nxt;
  logic          ack_r, ack_nxt;
  logic [7:0]    rx_r, rx_nxt;
  logic          is_read_r, is_read_nxt;
  logic          done, rej;
  logic          out_valid_r;
  res_t          res_r, res_nxt;
  logic          pop;
  logic          wait_end;
  logic [WW-1:0] wait_dec, ld_hi, ld_lo;
  logic [3:0]    idx_inc;

  assign q_ready   = !out_valid_r || out_ready;
  assign pop       = q_valid && q_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  assign wait_end = (wait_r <= WW'(1));
  assign wait_dec = wait_end ? '0 : wait_r - WW'(1);
  assign ld_hi    = wait_load(high_wait_r);
  assign ld_lo    = wait_load(low_wait_r);
  assign idx_inc  = bit_idx_r + 4'd1;

  always_comb begin
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    wait_nxt    = wait_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ack_nxt     = ack_r;
    rx_nxt      = rx_r;
    is_read_nxt = is_read_r;
    done        = 1'b0;
    rej         = 1'b0;
    if (q_item.is_cmd) begin
      if (phase_r != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        case (q_item.cmd)
          CMD_START: begin
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
            phase_nxt = PH_ST_RISE;
          end
          CMD_STOP: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_SP_FALL;
          end
          default: begin
            is_read_nxt = (q_item.cmd == CMD_READ);
            shift_nxt   = is_read_nxt ? 8'hFF : q_item.tx_byte;
            ack_nxt     = is_read_nxt ? q_item.ack_to_send : 1'b1;
            bit_idx_nxt = 4'd0;
            scl_nxt     = 1'b1;
            phase_nxt   = PH_BYTE_PREP;
          end
        endcase
      end
    end else begin
      case (phase_r)
        PH_ST_RISE: begin
          if (q_item.scl_level) begin
            wait_nxt  = ld_lo;
            phase_nxt = PH_ST_SETUP;
          end
        end
        PH_ST_SETUP: begin
          wait_nxt = wait_dec;
          if (wait_end) begin
            sda_nxt   = 1'b1;
            wait_nxt  = ld_hi;
            phase_nxt = PH_ST_HOLD;
          end
        end
        PH_ST_HOLD: begin
          wait_nxt = wait_dec;
          if (wait_end) begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_ST_FALL;
          end
        end
        PH_ST_FALL: begin
          if (!q_item.scl_level) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        end
        PH_BYTE_PREP: begin
          if (!q_item.scl_level) begin
            sda_nxt   = bit_pull(bit_idx_r, shift_r, ack_r);
            wait_nxt  = ld_lo;
            phase_nxt = PH_BIT_LOW;
          end
        end
        PH_BIT_LOW: begin
          wait_nxt = wait_dec;
          if (wait_end) begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_BIT_RISE;
          end
        end
        PH_BIT_RISE: begin
          if (q_item.scl_level) begin
            wait_nxt  = ld_hi;
            phase_nxt = PH_BIT_HIGH;
          end
        end
        PH_BIT_HIGH: begin
          wait_nxt = wait_dec;
          if (wait_end) begin
            if (bit_idx_r < 4'd8) begin
              rx_nxt = {rx_r[6:0], q_item.sda_level};
            end else begin
              ack_nxt = q_item.sda_level;
            end
            scl_nxt   = 1'b1;
            phase_nxt = PH_BIT_FALL;
          end
        end
        PH_BIT_FALL: begin
          if (!q_item.scl_level) begin
            bit_idx_nxt = idx_inc;
            if (idx_inc >= LAST_BIT) begin
              sda_nxt   = 1'b0;
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              sda_nxt   = bit_pull(idx_inc, shift_r, ack_r);
              wait_nxt  = ld_lo;
              phase_nxt = PH_BIT_LOW;
            end
          end
        end
        PH_SP_FALL: begin
          if (!q_item.scl_level) begin
            sda_nxt   = 1'b1;
            wait_nxt  = ld_lo;
            phase_nxt = PH_SP_LOW;
          end
        end
        PH_SP_LOW: begin
          wait_nxt = wait_dec;
          if (wait_end) begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_SP_RISE;
          end
        end
        PH_SP_RISE: begin
          if (q_item.scl_level) begin
            wait_nxt  = ld_lo;
            phase_nxt = PH_SP_SETUP;
          end
        end
        PH_SP_SETUP: begin
          wait_nxt = wait_dec;
          if (wait_end) begin
            sda_nxt   = 1'b0;
            wait_nxt  = ld_hi;
            phase_nxt = PH_SP_HOLD;
          end
        end
        PH_SP_HOLD: begin
          wait_nxt = wait_dec;
          if (wait_end) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    res_nxt.scl_pull_low = scl_nxt;
    res_nxt.sda_pull_low = sda_nxt;
    res_nxt.busy_res     = (phase_nxt != PH_IDLE);
    res_nxt.done_res     = done;
    res_nxt.rx_byte      = rx_nxt;
    res_nxt.ack_seen     = ack_nxt;
    res_nxt.rejected     = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_wait_r <= HIGH_WAIT_RST;
      low_wait_r  <= LOW_WAIT_RST;
      phase_r     <= PH_IDLE;
      bit_idx_r   <= 4'd0;
      shift_r     <= 8'hFF;
      wait_r      <= '0;
      scl_r       <= 1'b0;
      sda_r       <= 1'b0;
      ack_r       <= 1'b0;
      rx_r        <= 8'd0;
      is_read_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_HIGH_WAIT: high_wait_r <= cfg_data;
          CFG_LOW_WAIT:  low_wait_r  <= cfg_data;
          default:       ;
        endcase
      end
      if (pop) begin
        phase_r     <= phase_nxt;
        bit_idx_r   <= bit_idx_nxt;
        shift_r     <= shift_nxt;
        wait_r      <= wait_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        ack_r       <= ack_nxt;
        rx_r        <= rx_nxt;
        is_read_r   <= is_read_nxt;
        res_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/i2c_master_byte_engine.sv
`default_nettype none
// I2C master bit engine. Each beat on the input channel is either a tick,
// carrying the sampled SCL/SDA levels, or a host command (start, write byte,
// read byte, stop); every input beat yields exactly one result beat with the
// open-drain pulls, busy/done status, received byte, acknowledge and a reject
// flag for commands issued while busy. Items enter a two-entry queue and are
// executed one per clock, while the output does not stall, by the phase
// sequencer, which feeds an output register. An accepted item is written
// into the queue, and its result is registered in the output register.
// Wait registers (index 0 high dwell, index 1 low dwell) must be written by
// the user through the cfg port only while the engine is idle; the engine
// itself does not enforce this. cfg_ready is always high.
module i2c_master_byte_engine
  import i2cm_pkg::*;
#(
  parameter int WAIT_COUNTER_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_tx_byte,
  input  wire logic        in_ack_to_send,
  input  wire logic        in_scl_level,
  input  wire logic        in_sda_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_scl_pull_low,
  output logic             out_sda_pull_low,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [7:0]       out_rx_byte,
  output logic             out_ack_seen,
  output logic             out_rejected,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic  q_valid, q_ready;
  item_t q_item;
  res_t  res;

  assign cfg_ready = 1'b1;

  i2cm_front u_front (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_kind,
    .in_command,
    .in_tx_byte,
    .in_ack_to_send,
    .in_scl_level,
    .in_sda_level,
    .q_valid,
    .q_ready,
    .q_item
  );

  i2cm_back #(
    .WAIT_COUNTER_WIDTH(WAIT_COUNTER_WIDTH)
  ) u_back (
    .clk,
    .rst_n,
    .q_valid,
    .q_ready,
    .q_item,
    .cfg_valid,
    .cfg_index,
    .cfg_data,
    .out_valid,
    .out_ready,
    .out_res (res)
  );

  assign out_scl_pull_low = res.scl_pull_low;
  assign out_sda_pull_low = res.sda_pull_low;
  assign out_busy_res     = res.busy_res;
  assign out_done_res     = res.done_res;
  assign out_rx_byte      = res.rx_byte;
  assign out_ack_seen     = res.ack_seen;
  assign out_rejected     = res.rejected;

endmodule
`default_nettype wire

### hdl/i2cm_checker.sv
`default_nettype none
module i2cm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_busy_res,
  input wire logic       out_done_res,
  input wire logic       out_rejected,
  input wire logic [7:0] out_rx_byte
);

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done beat reports busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_busy_res && !out_done_res)
    else $error("reject without a command in progress");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rx_byte)
      && $stable(out_done_res))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_chk (.*);
`default_nettype wire
